// ===== src/swm_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the sliding window median filter.
// Holds default sizes, the window length register format and the cell control bundle.
package swm_pkg;

   localparam int WINDOW_MAX_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int             LEN_BITS  = 5;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 5'd3;

   // Control bundle driven by the top level into every cell.
   typedef struct packed {
      logic load;   // shift a new sample into the chain and restart ranking
      logic scan;   // one ranking step: compare, then pass rotating copy on
   } swm_ctrl_type;

endpackage

// ===== src/swm_cell.sv =====
`timescale 1ns / 1ps
// One cell of the median chain: a held sample, a rotating copy and a rank counter.
// Depends on swm_pkg for the control bundle.
module swm_cell import swm_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5,
   parameter int CELL_IDX    = 0
) (
   input  logic                          clock,
   input  swm_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] shift_data,
   input  logic signed [SAMPLE_BITS-1:0] nbr_rot_val,
   input  logic        [IDX_W-1:0]       nbr_rot_idx,
   input  logic        [CNT_W-1:0]       count,
   output logic signed [SAMPLE_BITS-1:0] held_val,
   output logic signed [SAMPLE_BITS-1:0] rot_val,
   output logic        [IDX_W-1:0]       rot_idx,
   output logic        [IDX_W-1:0]       rank
);

   logic signed [SAMPLE_BITS-1:0] held_ff, held_in;
   logic signed [SAMPLE_BITS-1:0] rot_val_ff, rot_val_in;
   logic        [IDX_W-1:0]       rot_idx_ff, rot_idx_in;
   logic        [IDX_W-1:0]       rank_ff, rank_in;
   logic                          rot_active;
   logic                          rot_less;

   // The rotating copy counts against this cell only if it is inside the window.
   // Equal values are ordered by age position so that every rank is distinct.
   assign rot_active = CNT_W'(rot_idx_ff) < count;
   assign rot_less   = (rot_val_ff < held_ff) ||
                       ((rot_val_ff == held_ff) && (rot_idx_ff < IDX_W'(CELL_IDX)));

   always_comb begin
      held_in    = held_ff;
      rot_val_in = rot_val_ff;
      rot_idx_in = rot_idx_ff;
      rank_in    = rank_ff;
      if (ctrl.load) begin
         held_in    = shift_data;
         rot_val_in = shift_data;
         rot_idx_in = IDX_W'(CELL_IDX);
         rank_in    = '0;
      end else if (ctrl.scan) begin
         rot_val_in = nbr_rot_val;
         rot_idx_in = nbr_rot_idx;
         if (rot_active && rot_less) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff    <= held_in;
      rot_val_ff <= rot_val_in;
      rot_idx_ff <= rot_idx_in;
      rank_ff    <= rank_in;
   end

   assign held_val = held_ff;
   assign rot_val  = rot_val_ff;
   assign rot_idx  = rot_idx_ff;
   assign rank     = rank_ff;

endmodule

// ===== src/sliding_window_median.sv =====
`timescale 1ns / 1ps
// Sliding window median filter, top level.
// Depends on swm_pkg and on the swm_cell chain.
//
// Usage: one signed sample per req_ transaction, one median per rsp_ transaction.
// The window length register is written through csr_valid/csr_window_length; the
// user must write it only while the block is idle; the block itself does not
// enforce this. 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX.
// The chain of WINDOW_MAX cells keeps the newest samples in age order. After a
// sample is taken, a copy of the window rotates once around the chain, so every
// cell counts how many window samples rank below its own. A select state then
// picks the middle pair and loads the result register. A new sample is taken
// only in the idle state, after the previous median has gone to the result register.
// The next sample may be accepted while a median waits in the result register;
// if the receiver still stalls when the next median is ready, the block holds
// in the select cycle until rsp_ready frees the register.
// A sample with req_last_of_stream set empties the window after its median.
// Synchronous reset empties the window, drops any pending result and sets the
// window length to 3; no clearing pass is needed.
module sliding_window_median import swm_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last_of_stream,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [LEN_BITS-1:0]    csr_window_length
);

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_SEL  = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;

   logic                          req_fire;
   logic                          rsp_load;
   logic [CNT_W-1:0]              fill_inc;
   logic [CNT_W-1:0]              eff_len;
   logic [CNT_W-1:0]              count_new;
   logic [IDX_W-1:0]              k_lo, k_hi;
   swm_ctrl_type                  ctrl;

   logic signed [SAMPLE_BITS-1:0] held_val [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] rot_val  [WINDOW_MAX];
   logic        [IDX_W-1:0]       rot_idx  [WINDOW_MAX];
   logic        [IDX_W-1:0]       rank     [WINDOW_MAX];
   logic        [WINDOW_MAX-1:0]  lo_hit, hi_hit;

   logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
   logic signed [SAMPLE_BITS:0]   pair_sum, pair_rnd;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign ctrl = '{load: req_fire, scan: (state_ff == ST_SCAN)};

   // Window size for the new sample: the register clamped to 1..WINDOW_MAX,
   // then limited to the samples held since the last clear.
   always_comb begin
      if (len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(len_ff) > WINDOW_MAX) begin
         eff_len = CNT_W'(WINDOW_MAX);
      end else begin
         eff_len = CNT_W'(len_ff);
      end
      fill_inc  = (32'(fill_ff) < WINDOW_MAX) ? fill_ff + CNT_W'(1) : fill_ff;
      count_new = (eff_len < fill_inc) ? eff_len : fill_inc;
   end

   assign k_lo = IDX_W'((count_ff - CNT_W'(1)) >> 1);
   assign k_hi = IDX_W'(count_ff >> 1);

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
         logic signed [SAMPLE_BITS-1:0] shift_src;
         logic                          cell_active;

         if (gi == 0) begin : g_head
            assign shift_src = req_sample;
         end else begin : g_body
            assign shift_src = held_val[gi-1];
         end

         swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX_W       (IDX_W),
            .CNT_W       (CNT_W),
            .CELL_IDX    (gi)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .shift_data  (shift_src),
            .nbr_rot_val (rot_val[(gi + 1) % WINDOW_MAX]),
            .nbr_rot_idx (rot_idx[(gi + 1) % WINDOW_MAX]),
            .count       (count_ff),
            .held_val    (held_val[gi]),
            .rot_val     (rot_val[gi]),
            .rot_idx     (rot_idx[gi]),
            .rank        (rank[gi])
         );

         assign cell_active = CNT_W'(gi) < count_ff;
         assign lo_hit[gi]  = cell_active && (rank[gi] == k_lo);
         assign hi_hit[gi]  = cell_active && (rank[gi] == k_hi);
      end
   endgenerate

   // Exactly one window cell holds each rank, so an OR of the gated values
   // selects the middle pair.
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         lo_val = lo_val | (held_val[i] & {SAMPLE_BITS{lo_hit[i]}});
         hi_val = hi_val | (held_val[i] & {SAMPLE_BITS{hi_hit[i]}});
      end
   end

   // Halving rounds toward zero: a negative sum is bumped by one before the shift.
   assign pair_sum = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
   assign pair_rnd = pair_sum + (SAMPLE_BITS+1)'(pair_sum[SAMPLE_BITS]);

   assign rsp_load = (state_ff == ST_SEL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;

      if (csr_valid && csr_ready) begin
         len_in = csr_window_length;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = count_new;
               fill_in  = req_last_of_stream ? '0 : fill_inc;
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(WINDOW_MAX - 1)) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = pair_rnd[SAMPLE_BITS:1];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         fill_ff      <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

`ifndef SYNTH
   // Every accepted sample starts a rotation over a non-empty window.
   a_accept_scan : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (count_ff != '0)
                   && (32'(count_ff) <= WINDOW_MAX))
      else $error("accepted sample did not start a scan over a valid window");

   // Ranks in the window are distinct, so each middle rank is held by one cell.
   a_lo_unique : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL) |-> $onehot(lo_hit))
      else $error("lower middle rank not held by exactly one cell");

   a_hi_unique : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL) |-> $onehot(hi_hit))
      else $error("upper middle rank not held by exactly one cell");

   // The fill count saturates at the chain length.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WINDOW_MAX)
      else $error("fill count exceeds chain length");
`endif

endmodule

// ===== bench/tb_sliding_window_median.sv =====
`timescale 1ns / 1ps
// Testbench for sliding_window_median: streams of signed samples under random flow control,
// each median checked against a behavioral window model. Depends on swm_pkg and the RTL.
module tb_sliding_window_median import swm_pkg::*;;

   localparam int WINDOW_MAX     = WINDOW_MAX_DEF;
   localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
   localparam int LATENCY        = WINDOW_MAX + 2;
   localparam int TIMEOUT_CYCLES = 2000;
   localparam int RANDOM_ITEMS   = 500;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   sample_type          req_sample = '0;
   logic                req_last_of_stream = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   sample_type          rsp_median;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LEN_BITS-1:0] csr_window_length = '0;

   // Window model state, updated once per accepted sample.
   sample_type          window_ring [WINDOW_MAX];
   int                  held_count = 0;
   int                  next_slot = 0;
   logic [LEN_BITS-1:0] window_len_cfg = LEN_RESET;

   sample_type expected_medians [$];
   sample_type median_want;
   int         error_count = 0;
   int         burst_left = 0;
   bit         sender_flood = 1'b0;
   int         rx_left = 0;
   int         idle_cycles = 0;

   sliding_window_median #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last_of_stream(req_last_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_median        (rsp_median),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Enters one sample into the model window and returns the median it should produce.
   function automatic sample_type next_median(input sample_type value,
                                              input logic end_of_stream);
      int sorted_vals [WINDOW_MAX];
      int span;
      int pos;
      int j;
      int v;
      int mid;
      window_ring[next_slot] = value;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (held_count < WINDOW_MAX) held_count++;
      if (window_len_cfg == 0) span = 1;
      else if (int'(window_len_cfg) > WINDOW_MAX) span = WINDOW_MAX;
      else span = int'(window_len_cfg);
      if (span > held_count) span = held_count;
      pos = next_slot;
      for (int i = 0; i < span; i++) begin
         pos = (pos + WINDOW_MAX - 1) % WINDOW_MAX;
         v = window_ring[pos];
         j = i;
         while (j > 0 && sorted_vals[j-1] > v) begin
            sorted_vals[j] = sorted_vals[j-1];
            j--;
         end
         sorted_vals[j] = v;
      end
      // Integer division truncates toward zero, as the even-count rule asks.
      if (span % 2 == 1) mid = sorted_vals[span/2];
      else mid = (sorted_vals[span/2 - 1] + sorted_vals[span/2]) / 2;
      if (end_of_stream) begin
         held_count = 0;
         next_slot = 0;
      end
      return sample_type'(mid);
   endfunction

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return $urandom_range(0, 1) ? sample_type'(16'h7fff) : sample_type'(16'h8000);
      if (pick <= 3) return sample_type'(int'($urandom_range(0, 8)) - 4);
      return sample_type'($urandom);
   endfunction

   // Leaves valid high after the transaction unless a gap follows, so bursts run
   // back to back.
   task automatic send_sample(input sample_type value, input logic end_of_stream);
      int gap;
      req_valid <= 1'b1;
      req_sample <= value;
      req_last_of_stream <= end_of_stream;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_medians.push_back(next_median(value, end_of_stream));
      if (!sender_flood) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 40);
            burst_left = $urandom_range(0, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain_medians();
      req_valid <= 1'b0;
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_window_length(input logic [LEN_BITS-1:0] len);
      csr_valid <= 1'b1;
      csr_window_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      window_len_cfg = len;
   endtask

   task automatic test_default_length();
      send_sample(sample_type'(10), 1'b0);
      send_sample(sample_type'(-20), 1'b0);
      send_sample(sample_type'(5), 1'b0);
      send_sample(sample_type'(32767), 1'b1);
      drain_medians();
   endtask

   // Pairs that exercise averaging at the extremes and truncation toward zero.
   task automatic test_even_average();
      write_window_length(LEN_BITS'(2));
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(32767), 1'b0);
      send_sample(sample_type'(32767), 1'b0);
      send_sample(sample_type'(-3), 1'b0);
      send_sample(sample_type'(0), 1'b0);
      send_sample(sample_type'(-32768), 1'b1);
      drain_medians();
   endtask

   task automatic test_length_zero();
      write_window_length(LEN_BITS'(0));
      send_sample(sample_type'(1234), 1'b0);
      send_sample(sample_type'(-1), 1'b1);
      drain_medians();
   endtask

   // All length bits set must saturate to the full window, including after the ring wraps.
   task automatic test_length_saturation();
      write_window_length('1);
      for (int i = 0; i < WINDOW_MAX + 1; i++)
         send_sample(random_sample(), i == WINDOW_MAX);
      drain_medians();
   endtask

   // Windows are not always cleared at a phase end, so length changes also land mid-stream.
   task automatic test_random_streams();
      logic [LEN_BITS-1:0] fixed_lengths [5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17};
      logic [LEN_BITS-1:0] len;
      int sent;
      int phase;
      int count;
      int last_odds;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 5) len = fixed_lengths[phase];
         else if ($urandom_range(0, 3) == 0) len = LEN_BITS'($urandom_range(0, 31));
         else len = LEN_BITS'($urandom_range(1, WINDOW_MAX));
         write_window_length(len);
         sender_flood = ($urandom_range(0, 3) == 0);
         count = $urandom_range(8, 50);
         last_odds = $urandom_range(4, 40);
         for (int i = 0; i < count; i++)
            send_sample(random_sample(), $urandom_range(1, last_odds) == 1);
         drain_medians();
         sent += count;
         phase++;
      end
      sender_flood = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_medians.size() == 0) begin
            report_error($sformatf("median %0d with no sample pending", rsp_median));
         end else begin
            median_want = expected_medians.pop_front();
            if (rsp_median !== median_want)
               report_error($sformatf("median got %0d, want %0d", rsp_median, median_want));
         end
      end
   end

   // The receiver alternates long free stretches, hard stalls and random flicker.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b0;
               rx_left <= $urandom_range(1, 30);
            end
            1: begin
               rsp_ready <= 1'b1;
               rx_left <= $urandom_range(100, 300);
            end
            default: begin
               rsp_ready <= 1'($urandom_range(0, 1));
               rx_left <= $urandom_range(1, 8);
            end
         endcase
      end else begin
         rx_left <= rx_left - 1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= TIMEOUT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_length();
      test_even_average();
      test_length_zero();
      test_length_saturation();
      test_random_streams();
      if (expected_medians.size() != 0)
         report_error($sformatf("%0d medians never arrived", expected_medians.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median.sv
bench/tb_sliding_window_median.sv
